// ----- rtl/core/jacobi_laplace_grid_solver_defines.svh -----
// Assertion macros shared by the solver RTL.
`ifndef JACOBI_LAPLACE_GRID_SOLVER_DEFINES_SVH
`define JACOBI_LAPLACE_GRID_SOLVER_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define JLS_ASSERT_HOLDS(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define JLS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/core/jls_pkg.sv -----
`timescale 1ns / 1ps
package jls_pkg;

   localparam int MAX_SIDE     = 128;
   localparam int CHECK_PERIOD = 100;

   localparam int IDX_W   = $clog2(MAX_SIDE);
   localparam int SIDE_W  = $clog2(MAX_SIDE + 1);
   localparam int ADDR_W  = 2 * IDX_W;
   localparam int DEPTH   = MAX_SIDE * MAX_SIDE;
   localparam int DATA_W  = 32;
   localparam int STEP_W  = 27;
   localparam int CNT_W   = 24;
   localparam int PHASE_W = $clog2(CHECK_PERIOD + 1);
   localparam int EDGE_W  = STEP_W + IDX_W + 1;
   localparam int SUM_W   = DATA_W + 2;

   localparam logic [DATA_W-1:0] QONE      = 32'h0100_0000;
   localparam logic [DATA_W-1:0] CORNER_LO = 32'h0A00_0000;
   localparam logic [DATA_W-1:0] CORNER_MD = 32'h1400_0000;
   localparam logic [DATA_W-1:0] CORNER_HI = 32'h1E00_0000;

   // Pipeline depth from read issue to the last error update.
   localparam logic [2:0] DRAIN_CYCLES = 3'd7;

   localparam logic CSR_GRID_SIZE     = 1'b0;
   localparam logic CSR_BOUNDARY_STEP = 1'b1;

   localparam logic [7:0]        GRID_SIZE_RESET = 8'd128;
   localparam logic [STEP_W-1:0] STEP_RESET      = 27'd1321041;

   typedef struct packed {
      logic [DATA_W-1:0] top;
      logic [DATA_W-1:0] mid;
      logic [DATA_W-1:0] bot;
   } column_type;

   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] addr;
      logic [DATA_W-1:0] data;
   } store_wr_type;

endpackage

// ----- rtl/core/jls_cell.sv -----
`timescale 1ns / 1ps
// One stencil cell: holds a three-row column slice and passes it on each cycle.
module jls_cell (
   input  logic                clock,
   input  jls_pkg::column_type col_in,
   output jls_pkg::column_type col_out
);
   import jls_pkg::*;

   column_type col_ff;

   always_ff @(posedge clock) begin
      col_ff <= col_in;
   end

   assign col_out = col_ff;
endmodule

// ----- rtl/core/jls_line_buffer.sv -----
`timescale 1ns / 1ps
// Row delay line: returns the value written at the same column one row earlier.
module jls_line_buffer (
   input  logic                            clock,
   input  logic [jls_pkg::IDX_W-1:0]       ptr,
   input  logic [jls_pkg::DATA_W-1:0]      wdata,
   output logic [jls_pkg::DATA_W-1:0]      rdata
);
   import jls_pkg::*;

   logic [DATA_W-1:0] mem [MAX_SIDE];
   logic [DATA_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      rdata_ff <= mem[ptr];
      mem[ptr] <= wdata;
   end

   assign rdata = rdata_ff;
endmodule

// ----- rtl/core/jls_store.sv -----
`timescale 1ns / 1ps
// One grid store: one write port, one registered read port.
module jls_store (
   input  logic                         clock,
   input  jls_pkg::store_wr_type        wr,
   input  logic [jls_pkg::ADDR_W-1:0]   raddr,
   output logic [jls_pkg::DATA_W-1:0]   rdata
);
   import jls_pkg::*;

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (wr.we) begin
         mem[wr.addr] <= wr.data;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// ----- rtl/core/jacobi_laplace_grid_solver.sv -----
`timescale 1ns / 1ps
// Jacobi solver for the five-point Laplace stencil. Each request transaction
// (tolerance, iteration limit) first rebuilds both grid stores, N*N points at
// one point per cycle, where N is grid_size clamped to 3..MAX_SIDE. Each
// sweep then streams the current store row by row, one point per cycle,
// through two row delay lines and a chain of three stencil cells, and
// writes the new interior into the other store. The response transaction
// carries the sweep count, the last measured error and the limit flag; it
// waits in an output register, so a new request is taken while it is still
// pending.
module jacobi_laplace_grid_solver (
   input  logic        clock,
   input  logic        reset,
   // [31:0] tolerance, [55:32] iteration_limit
   input  logic [55:0] req_tdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [23:0] sweeps_done, [55:24] final_error, [56] limit_reached
   output logic [63:0] rsp_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [26:0] csr_wdata
);
   import jls_pkg::*;

`include "jacobi_laplace_grid_solver_defines.svh"

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INIT,
      ST_CHECK,
      ST_SWEEP,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   // Configuration registers.
   logic [7:0]        grid_size_ff;
   logic [STEP_W-1:0] step_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_size_ff <= GRID_SIZE_RESET;
         step_ff      <= STEP_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_GRID_SIZE:     grid_size_ff <= csr_wdata[7:0];
            CSR_BOUNDARY_STEP: step_ff      <= csr_wdata;
            default:           ;
         endcase
      end
   end

   // Control state.
   state_type         state_ff;
   logic [SIDE_W-1:0] n_ff;
   logic [DATA_W-1:0] tol_ff;
   logic [CNT_W-1:0]  lim_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [DATA_W-1:0] err_ff;
   logic [PHASE_W-1:0] phase_ff;
   logic              active_ff;
   logic [IDX_W-1:0]  r0_ff, c0_ff;
   logic [2:0]        drain_ff;
   logic              rsp_valid_ff;
   logic [CNT_W-1:0]  rsp_cnt_ff;
   logic [DATA_W-1:0] rsp_err_ff;
   logic              rsp_flag_ff;
   logic [DATA_W-1:0] worst_ff;

   logic [SIDE_W-1:0]  n_in;
   logic [IDX_W-1:0]   last_idx;
   logic               walk_last;
   logic [CNT_W-1:0]   cnt_in;
   logic [PHASE_W-1:0] phase_in;

   always_comb begin
      if (32'(grid_size_ff) < 32'd3) begin
         n_in = SIDE_W'(3);
      end else if (32'(grid_size_ff) > 32'(MAX_SIDE)) begin
         n_in = SIDE_W'(MAX_SIDE);
      end else begin
         n_in = SIDE_W'(grid_size_ff);
      end
   end

   assign last_idx  = IDX_W'(n_ff - SIDE_W'(1));
   assign walk_last = (r0_ff == last_idx) && (c0_ff == last_idx);
   assign cnt_in    = cnt_ff + CNT_W'(1);
   assign phase_in  = (phase_ff == PHASE_W'(CHECK_PERIOD - 1)) ? '0 : phase_ff + PHASE_W'(1);

   assign req_tready = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         err_ff       <= QONE;
         active_ff    <= 1'b0;
         phase_ff     <= '0;
         r0_ff        <= '0;
         c0_ff        <= '0;
         drain_ff     <= '0;
      end else begin
         // In the finish state the response register is handled below.
         if (rsp_valid_ff && rsp_tready && state_ff != ST_FINISH) begin
            rsp_valid_ff <= 1'b0;
         end
         if (state_ff == ST_INIT || state_ff == ST_SWEEP) begin
            if (c0_ff == last_idx) begin
               c0_ff <= '0;
               r0_ff <= r0_ff + IDX_W'(1);
            end else begin
               c0_ff <= c0_ff + IDX_W'(1);
            end
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  tol_ff    <= req_tdata[31:0];
                  lim_ff    <= req_tdata[55:32];
                  n_ff      <= n_in;
                  cnt_ff    <= '0;
                  err_ff    <= QONE;
                  active_ff <= 1'b0;
                  phase_ff  <= '0;
                  r0_ff     <= '0;
                  c0_ff     <= '0;
                  state_ff  <= ST_INIT;
               end
            end
            ST_INIT: begin
               if (walk_last) begin
                  state_ff <= ST_CHECK;
               end
            end
            ST_CHECK: begin
               r0_ff <= '0;
               c0_ff <= '0;
               if (err_ff > tol_ff && cnt_ff < lim_ff) begin
                  state_ff <= ST_SWEEP;
               end else begin
                  state_ff <= ST_FINISH;
               end
            end
            ST_SWEEP: begin
               drain_ff <= DRAIN_CYCLES;
               if (walk_last) begin
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               drain_ff <= drain_ff - 3'd1;
               if (drain_ff == 3'd1) begin
                  // The sweep is complete: count it and measure on check sweeps.
                  cnt_ff    <= cnt_in;
                  phase_ff  <= phase_in;
                  active_ff <= ~active_ff;
                  if (phase_in == '0 || cnt_in == CNT_W'(1)) begin
                     err_ff <= worst_ff;
                  end
                  state_ff <= ST_CHECK;
               end
            end
            ST_FINISH: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_cnt_ff   <= cnt_ff;
                  rsp_err_ff   <= err_ff;
                  rsp_flag_ff  <= (err_ff > tol_ff);
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_flag_ff, rsp_err_ff, rsp_cnt_ff};

   // Boundary value for the point being built; corners carry their own base.
   logic [IDX_W-1:0]  edge_i;
   logic [DATA_W-1:0] edge_base;
   logic              on_edge;
   logic [EDGE_W-1:0] edge_sum;
   logic [DATA_W-1:0] init_val;

   always_comb begin
      on_edge   = 1'b1;
      edge_i    = '0;
      edge_base = CORNER_LO;
      if ((r0_ff == '0 && c0_ff == last_idx) || (r0_ff == last_idx && c0_ff == '0)) begin
         edge_base = CORNER_MD;
      end else if (r0_ff == last_idx && c0_ff == last_idx) begin
         edge_base = CORNER_HI;
      end else if (r0_ff == '0) begin
         edge_i = c0_ff;
      end else if (c0_ff == '0) begin
         edge_i = r0_ff;
      end else if (r0_ff == last_idx) begin
         edge_base = CORNER_MD;
         edge_i    = c0_ff;
      end else if (c0_ff == last_idx) begin
         edge_base = CORNER_MD;
         edge_i    = r0_ff;
      end else begin
         on_edge = 1'b0;
      end
      edge_sum = EDGE_W'(edge_base) + EDGE_W'(step_ff) * EDGE_W'(edge_i);
      if (!on_edge) begin
         init_val = '0;
      end else if (edge_sum > EDGE_W'(32'hFFFF_FFFF)) begin
         init_val = 32'hFFFF_FFFF;
      end else begin
         init_val = edge_sum[DATA_W-1:0];
      end
   end

   // Stencil pipeline stages.
   logic              v1_ff, v2_ff, v3_ff, v4_ff, ok5_ff, ok6_ff;
   logic [IDX_W-1:0]  r1_ff, r2_ff, r3_ff, r4_ff;
   logic [IDX_W-1:0]  c1_ff, c2_ff, c3_ff, c4_ff;
   logic [DATA_W-1:0] q2_ff, q3_ff, lb1d_ff;
   logic [DATA_W-1:0] v5_ff, old5_ff, d6_ff;
   logic [ADDR_W-1:0] addr5_ff;
   logic [DATA_W-1:0] a_rd, b_rd, q1, lb1_out, lb2_out;
   logic [SUM_W-1:0]  stencil_sum;
   logic [DATA_W-1:0] diff5;
   column_type        col3, col_c0, col_c1, col_c2;
   store_wr_type      wr_a, wr_b;
   logic              init_we;

   assign q1 = active_ff ? b_rd : a_rd;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff  <= 1'b0;
         v2_ff  <= 1'b0;
         v3_ff  <= 1'b0;
         v4_ff  <= 1'b0;
         ok5_ff <= 1'b0;
         ok6_ff <= 1'b0;
      end else begin
         v1_ff  <= (state_ff == ST_SWEEP);
         v2_ff  <= v1_ff;
         v3_ff  <= v2_ff;
         v4_ff  <= v3_ff;
         ok5_ff <= v4_ff && (r4_ff >= IDX_W'(2)) && (c4_ff >= IDX_W'(2));
         ok6_ff <= ok5_ff;
      end
   end

   always_ff @(posedge clock) begin
      r1_ff    <= r0_ff;
      c1_ff    <= c0_ff;
      r2_ff    <= r1_ff;
      c2_ff    <= c1_ff;
      r3_ff    <= r2_ff;
      c3_ff    <= c2_ff;
      r4_ff    <= r3_ff;
      c4_ff    <= c3_ff;
      q2_ff    <= q1;
      q3_ff    <= q2_ff;
      lb1d_ff  <= lb1_out;
      v5_ff    <= stencil_sum[SUM_W-1:2];
      old5_ff  <= col_c1.mid;
      addr5_ff <= {r4_ff - IDX_W'(1), c4_ff - IDX_W'(1)};
      d6_ff    <= diff5;
   end

   // Largest change of the running sweep.
   always_ff @(posedge clock) begin
      if (state_ff == ST_CHECK) begin
         worst_ff <= '0;
      end else if (ok6_ff && d6_ff > worst_ff) begin
         worst_ff <= d6_ff;
      end
   end

   jls_line_buffer u_lb1 (
      .clock (clock),
      .ptr   (c1_ff),
      .wdata (q1),
      .rdata (lb1_out)
   );

   jls_line_buffer u_lb2 (
      .clock (clock),
      .ptr   (c2_ff),
      .wdata (lb1_out),
      .rdata (lb2_out)
   );

   assign col3 = '{top: lb2_out, mid: lb1d_ff, bot: q3_ff};

   // Cell 0 holds the right column, cell 1 the center, cell 2 the left.
   jls_cell u_cell0 (.clock(clock), .col_in(col3),   .col_out(col_c0));
   jls_cell u_cell1 (.clock(clock), .col_in(col_c0), .col_out(col_c1));
   jls_cell u_cell2 (.clock(clock), .col_in(col_c1), .col_out(col_c2));

   assign stencil_sum = SUM_W'(col_c1.top) + SUM_W'(col_c1.bot)
                      + SUM_W'(col_c0.mid) + SUM_W'(col_c2.mid);
   assign diff5 = (v5_ff > old5_ff) ? v5_ff - old5_ff : old5_ff - v5_ff;

   // Both stores are built together; a sweep writes the store it does not read.
   assign init_we = (state_ff == ST_INIT);

   always_comb begin
      wr_a.we   = init_we || (ok5_ff && active_ff);
      wr_a.addr = init_we ? {r0_ff, c0_ff} : addr5_ff;
      wr_a.data = init_we ? init_val : v5_ff;
      wr_b.we   = init_we || (ok5_ff && !active_ff);
      wr_b.addr = wr_a.addr;
      wr_b.data = wr_a.data;
   end

   jls_store u_store_a (
      .clock (clock),
      .wr    (wr_a),
      .raddr ({r0_ff, c0_ff}),
      .rdata (a_rd)
   );

   jls_store u_store_b (
      .clock (clock),
      .wr    (wr_b),
      .raddr ({r0_ff, c0_ff}),
      .rdata (b_rd)
   );

   `JLS_ASSERT_HOLDS(a_cnt_within_limit,
      (state_ff != ST_CHECK) || (cnt_ff <= lim_ff), "sweep count passed the limit")
   `JLS_ASSERT_NEXT(a_rsp_from_finish, !rsp_valid_ff && state_ff != ST_FINISH,
      !rsp_valid_ff, "response raised outside finish")
   `JLS_ASSERT_NEXT(a_sweep_ends_in_drain, state_ff == ST_SWEEP && walk_last,
      state_ff == ST_DRAIN, "sweep did not drain")

endmodule
